[src/spgm_pkg.sv]
// Shared types, constants and elaboration-time sine helpers for the stereo pan gain mixer.
`default_nettype none

package spgm_pkg;

    localparam int DATA_W = 16;
    localparam int ACC_W  = 40;

    localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1847;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic [DATA_W-1:0] gain;
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
        logic              en;
    } t_chan_entry;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [15:0] sine_series(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        x2   = q60_mul(x, x);
        term = x;
        sum  = x;
        term = q60_mul(term, x2) / 64'd6;   sum = sum - term;
        term = q60_mul(term, x2) / 64'd20;  sum = sum + term;
        term = q60_mul(term, x2) / 64'd42;  sum = sum - term;
        term = q60_mul(term, x2) / 64'd72;  sum = sum + term;
        term = q60_mul(term, x2) / 64'd110; sum = sum - term;
        term = q60_mul(term, x2) / 64'd156; sum = sum + term;
        term = q60_mul(term, x2) / 64'd210; sum = sum - term;
        term = q60_mul(term, x2) / 64'd272; sum = sum + term;
        term = q60_mul(term, x2) / 64'd342; sum = sum - term;
        term = q60_mul(term, x2) / 64'd420; sum = sum + term;
        term = q60_mul(term, x2) / 64'd506; sum = sum - term;
        term = q60_mul(term, x2) / 64'd600; sum = sum + term;
        term = q60_mul(term, x2) / 64'd702; sum = sum - term;
        rnd  = sum + 64'h0000_1000_0000_0000;
        return rnd[60:45];
    endfunction

    function automatic t_acc acc_add(t_acc a, logic signed [20:0] d);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W-20){d[20]}}, d};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    function automatic logic signed [31:0] out_clamp(t_acc a);
        if ((a[ACC_W-1:31] == '0) || (a[ACC_W-1:31] == '1)) begin
            return a[31:0];
        end
        return a[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic [DATA_W-1:0] out_sat(logic signed [48:0] p);
        logic [34:0] w;
        w = p[48:14];
        if ((w[34:15] == '0) || (w[34:15] == '1)) begin
            return w[15:0];
        end
        return w[34] ? 16'h8000 : 16'h7FFF;
    endfunction

endpackage

`default_nettype wire

[src/spgm_sine_rom.sv]
// Quarter-sine coefficient ROM, built at elaboration, with a registered read port.
`default_nettype none

module spgm_sine_rom
    import spgm_pkg::*;
#(
    parameter int SINE_STEPS = 256
) (
    input  wire logic                             i_clk,
    input  wire logic [$clog2(SINE_STEPS+1)-1:0]  i_addr,
    output logic      [DATA_W-1:0]                o_data
);

    localparam logic [63:0] STEP_Q = HALF_PI_Q60 / 64'(SINE_STEPS);
    localparam logic [63:0] STEP_R = HALF_PI_Q60 % 64'(SINE_STEPS);

    typedef logic [DATA_W-1:0] t_rom [0:SINE_STEPS];

    function automatic t_rom build_rom();
        t_rom t;
        for (int k = 0; k <= SINE_STEPS; k++) begin
            t[k] = sine_series(STEP_Q * 64'(k) + (STEP_R * 64'(k)) / 64'(SINE_STEPS));
        end
        return t;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[src/stereo_pan_gain_mixer.sv]
// Stereo mixer with per-channel gain, constant-power pan and master gain.
//
// Input channel s_axis: one transfer per item. tuser is the mode (0 channel setup,
// 1 sample), tlast marks the last sample of an output frame. A setup stores the
// channel gain, enable and a left/right coefficient pair read from a quarter-sine
// ROM. A sample of an enabled channel adds sample*gain*coef into two 40-bit
// saturating accumulators.
// Output channel m_axis: one transfer per frame, sent after a sample with tlast;
// both accumulators are scaled by master gain, saturated to 16 bits and cleared.
// Steps: a sample goes through channel memory read, gain multiply, pan multiply
// and accumulate; a setup goes through pan index multiply, two reads of the
// single ROM port and memory write. A frame end adds output multiply and
// saturate before the result register loads. s_axis_tready is high only between
// items. The result register holds one frame; while it is full and m_axis_tready
// is low, a further frame end waits in place and no new item is taken.
// Reset clears channel valid bits (all channels inactive, memory not cleared),
// both accumulators and the output valid flag, and sets master gain to unity.
// The master gain port i_cfg_we/i_cfg_wdata writes the master gain register.
`default_nettype none

module stereo_pan_gain_mixer
    import spgm_pkg::*;
#(
    parameter int CHANNELS   = 16,
    parameter int SINE_STEPS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // channel, sample, gain, pan, enable, zero pad
    input  wire logic        s_axis_tuser,   // mode
    input  wire logic        s_axis_tlast,   // frame_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // left_out, right_out
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW   = $clog2(SINE_STEPS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KCALC = 4'd1;
    localparam logic [3:0] S_RDR   = 4'd2;
    localparam logic [3:0] S_RDL   = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_OMUL  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]          r_state, n_state;
    logic [CHANNELS-1:0] r_valid;
    logic [15:0]         r_master_gain;
    t_acc                r_acc_l, r_acc_r;
    logic                r_out_valid;
    logic [31:0]         r_out_data;

    t_chan_entry         r_mem [0:CHANNELS-1];
    t_chan_entry         r_rd;
    logic                r_rd_valid;

    logic [CH_W-1:0]     r_addr;
    logic                r_ok;
    logic signed [15:0]  r_sample;
    logic [15:0]         r_gain;
    logic [15:0]         r_pan;
    logic                r_en;
    logic                r_fe;
    logic [AW-1:0]       r_k;
    logic [15:0]         r_right;
    logic signed [32:0]  r_p1;
    logic signed [35:0]  r_pl, r_pr;
    logic signed [48:0]  r_ol, r_or;

    logic                w_in_xfer;
    logic [CH_W+3:0]     w_in_ext;
    logic [CH_W-1:0]     w_in_addr;
    logic                w_in_ok;
    logic [31:0]         w_k_prod;
    logic [AW-1:0]       w_rom_addr;
    logic [15:0]         w_rom_data;
    logic signed [32:0]  w_p1;
    logic signed [18:0]  w_v;
    logic signed [35:0]  w_pl, w_pr;
    logic signed [48:0]  w_ol, w_or;
    logic                w_out_load;
    logic                w_mem_we;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_in_ext      = {{CH_W{1'b0}}, s_axis_tdata[3:0]};
    assign w_in_addr     = w_in_ext[CH_W-1:0];
    assign w_in_ok       = ({3'b000, s_axis_tdata[3:0]} < 7'(CHANNELS));

    assign w_k_prod   = {16'd0, r_pan ^ 16'h8000} * 32'(SINE_STEPS);
    assign w_rom_addr = (r_state == S_RDL) ? (AW'(SINE_STEPS) - r_k) : r_k;

    spgm_sine_rom #(
        .SINE_STEPS (SINE_STEPS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    assign w_p1 = r_sample * $signed({1'b0, r_rd.gain});
    assign w_v  = r_p1[32:14];
    assign w_pl = w_v * $signed({1'b0, r_rd.left});
    assign w_pr = w_v * $signed({1'b0, r_rd.right});
    assign w_ol = out_clamp(r_acc_l) * $signed({1'b0, r_master_gain});
    assign w_or = out_clamp(r_acc_r) * $signed({1'b0, r_master_gain});

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);
    assign w_mem_we   = (r_state == S_WR) && r_ok;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = s_axis_tuser ? S_MUL1 : S_KCALC;
                end
            end
            S_KCALC: n_state = S_RDR;
            S_RDR:   n_state = S_RDL;
            S_RDL:   n_state = S_WR;
            S_WR:    n_state = S_IDLE;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_ACC;
            S_ACC:   n_state = r_fe ? S_OMUL : S_IDLE;
            S_OMUL:  n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_master_gain <= 16'd16384;
            r_acc_l       <= '0;
            r_acc_r       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_master_gain <= i_cfg_wdata;
            end
            if (w_mem_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (r_state == S_ACC) begin
                r_acc_l <= acc_add(r_acc_l, r_pl[35:15]);
                r_acc_r <= acc_add(r_acc_r, r_pr[35:15]);
            end else if (w_out_load) begin
                r_acc_l <= '0;
                r_acc_r <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_addr] <= '{gain: r_gain, left: w_rom_data, right: r_right, en: r_en};
        end
        if (w_in_xfer) begin
            r_rd       <= r_mem[w_in_addr];
            r_rd_valid <= r_valid[w_in_addr];
            r_addr     <= w_in_addr;
            r_ok       <= w_in_ok;
            r_sample   <= s_axis_tdata[19:4];
            r_gain     <= s_axis_tdata[35:20];
            r_pan      <= s_axis_tdata[51:36];
            r_en       <= s_axis_tdata[52];
            r_fe       <= s_axis_tlast;
        end
        if (r_state == S_KCALC) begin
            r_k <= w_k_prod[16 +: AW];
        end
        if (r_state == S_RDL) begin
            r_right <= w_rom_data;
        end
        if (r_state == S_MUL1) begin
            r_p1 <= (r_ok && r_rd_valid && r_rd.en) ? w_p1 : '0;
        end
        if (r_state == S_MUL2) begin
            r_pl <= w_pl;
            r_pr <= w_pr;
        end
        if (r_state == S_OMUL) begin
            r_ol <= w_ol;
            r_or <= w_or;
        end
        if (w_out_load) begin
            r_out_data <= {out_sat(r_or), out_sat(r_ol)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_acc_l == '0) && (r_acc_r == '0))
        else $error("accumulators not cleared after frame emit");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_KCALC) || (r_state == S_MUL1))
        else $error("accepted item did not start processing");

    a_valid_only_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_state != S_WR)) |=> (r_valid == $past(r_valid)))
        else $error("channel valid bits changed outside a setup write");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("output loaded outside the emit step");
`endif

endmodule

`default_nettype wire
